@@ rtl/core/tlpg_pkg.sv @@
`default_nettype none

package tlpg_pkg;

  // Frame buffer geometry, three bytes per pixel
  localparam int IMAGE_WIDTH  = 256;
  localparam int IMAGE_HEIGHT = 256;
  localparam int BYTES_PER_PIX = 3;

  // Field widths
  localparam int COORD_W = 8;
  localparam int ROW_W   = 10;
  localparam int ERR_W   = 10;
  localparam int E2_W    = ERR_W + 1;
  localparam int OFS_W   = 5;
  localparam int LIM_W   = 4;
  localparam int THICK_W = 5;
  localparam int COLOR_W = 24;
  localparam int CHAN_W  = 8;
  localparam int ADDR_W  = 18;
  localparam int LIN_W   = 32;

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Pixel handed from the stepper to the pixel formatter
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [ROW_W-1:0]   y;     // two's complement row
    logic               last;
  } tlpg_pix_t;

endpackage

`default_nettype wire

@@ rtl/core/thick_line_pixel_generator_unit.sv @@
`default_nettype none

// Thick line pixel generator. A start transaction (op = 0) latches two
// endpoints, a 24-bit color and a thickness t and returns nothing; each step
// transaction (op = 1) returns the next pixel of the line: column, signed row,
// an on-image flag, the frame buffer byte offset (y*W+x)*3 of its red byte
// (0 when off image), the color bytes and a flag on the final pixel. The line
// is drawn as Bresenham passes at row offsets -t/2 .. +t/2. A step with no
// line in progress is consumed and returns nothing; a start drops any line
// in progress. The pixel is combinational from the walker registers into the
// result register while the Bresenham update returns to the walker registers,
// so a new transaction is taken each cycle unless stalled, and the pixel shows
// on out_ in the cycle after its step is taken. in_ready is low only while a
// result sits in the output register and out_ready is low.

module thick_line_pixel_generator_unit
  import tlpg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_op,
  input  wire logic [COORD_W-1:0] in_x_start,
  input  wire logic [COORD_W-1:0] in_y_start,
  input  wire logic [COORD_W-1:0] in_x_end,
  input  wire logic [COORD_W-1:0] in_y_end,
  input  wire logic [COLOR_W-1:0] in_color,
  input  wire logic [THICK_W-1:0] in_thickness,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [COORD_W-1:0]      out_pixel_x,
  output logic signed [ROW_W-1:0] out_pixel_y,
  output logic                    out_on_image,
  output logic [ADDR_W-1:0]       out_byte_address,
  output logic [CHAN_W-1:0]       out_red,
  output logic [CHAN_W-1:0]       out_green,
  output logic [CHAN_W-1:0]       out_blue,
  output logic                    out_last_pixel
);

  logic               in_fire;
  logic               load;
  logic               advance;
  logic               line_active;
  tlpg_pix_t          pix;
  logic [COLOR_W-1:0] line_color;

  logic               on_image;
  logic [ADDR_W-1:0]  byte_address;
  logic [CHAN_W-1:0]  red;
  logic [CHAN_W-1:0]  green;
  logic [CHAN_W-1:0]  blue;

  logic               out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0] pixel_x_r;
  logic [ROW_W-1:0]   pixel_y_r;
  logic               on_image_r;
  logic [ADDR_W-1:0]  byte_address_r;
  logic [CHAN_W-1:0]  red_r;
  logic [CHAN_W-1:0]  green_r;
  logic [CHAN_W-1:0]  blue_r;
  logic               last_r;

  // Take a transaction whenever the result register is empty or draining
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign load     = in_fire && (in_op == OP_START);
  // Only a step with a line in progress moves the walker and yields a pixel
  assign advance  = in_fire && (in_op == OP_STEP) && line_active;

  tlpg_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .advance    (advance),
    .x_start    (in_x_start),
    .y_start    (in_y_start),
    .x_end      (in_x_end),
    .y_end      (in_y_end),
    .color      (in_color),
    .thickness  (in_thickness),
    .active     (line_active),
    .pix        (pix),
    .line_color (line_color)
  );

  tlpg_pixel u_pixel (
    .pix          (pix),
    .line_color   (line_color),
    .on_image     (on_image),
    .byte_address (byte_address),
    .red          (red),
    .green        (green),
    .blue         (blue)
  );

  // Fill on a pixel-producing step, drop once the consumer takes it, else hold
  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: no reset needed, qualified by out_valid_r
  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_x_r      <= pix.x;
      pixel_y_r      <= pix.y;
      on_image_r     <= on_image;
      byte_address_r <= byte_address;
      red_r          <= red;
      green_r        <= green;
      blue_r         <= blue;
      last_r         <= pix.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = pixel_x_r;
  assign out_pixel_y      = $signed(pixel_y_r);
  assign out_on_image     = on_image_r;
  assign out_byte_address = byte_address_r;
  assign out_red          = red_r;
  assign out_green        = green_r;
  assign out_blue         = blue_r;
  assign out_last_pixel   = last_r;

  // A start transaction never leaves a result behind
  a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> !out_valid_r)
    else $error("start transaction produced a result");

  // A step with no line in progress never leaves a result behind
  a_idle_step_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_op == OP_STEP) && !line_active) |=> !out_valid_r)
    else $error("idle step produced a result");

  // Off-image pixels carry a zero address so nothing gets written
  a_offimage_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !on_image_r) |-> (byte_address_r == '0))
    else $error("off-image pixel with nonzero address");

endmodule

`default_nettype wire

@@ rtl/core/tlpg_step.sv @@
`default_nettype none

module tlpg_step
  import tlpg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire logic               advance,
  input  wire logic [COORD_W-1:0] x_start,
  input  wire logic [COORD_W-1:0] y_start,
  input  wire logic [COORD_W-1:0] x_end,
  input  wire logic [COORD_W-1:0] y_end,
  input  wire logic [COLOR_W-1:0] color,
  input  wire logic [THICK_W-1:0] thickness,
  output logic                    active,
  output tlpg_pix_t               pix,
  output logic [COLOR_W-1:0]      line_color
);

  logic               active_r, active_nxt;
  logic [COORD_W-1:0] cur_x_r, cur_x_nxt;
  logic [ROW_W-1:0]   cur_y_r, cur_y_nxt;
  logic [ERR_W-1:0]   err_r, err_nxt;
  logic [COORD_W-1:0] dx_r, dx_nxt;
  logic [COORD_W-1:0] dy_r, dy_nxt;
  logic               sxn_r, sxn_nxt;
  logic               syn_r, syn_nxt;
  logic [COORD_W-1:0] x0_r, x0_nxt;
  logic [COORD_W-1:0] y0_r, y0_nxt;
  logic [COORD_W-1:0] x1_r, x1_nxt;
  logic [COORD_W-1:0] y1_r, y1_nxt;
  logic [OFS_W-1:0]   ofs_r, ofs_nxt;
  logic [LIM_W-1:0]   lim_r, lim_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;

  logic [ROW_W-1:0]   end_y;
  logic [OFS_W-1:0]   ofs_inc;
  logic               at_end;
  logic               final_pass;
  logic [E2_W-1:0]    e2;
  logic [E2_W-1:0]    err_sum;
  logic               move_x;
  logic               move_y;

  always_comb begin
    end_y      = ROW_W'({2'b00, y1_r}) + {{(ROW_W-OFS_W){ofs_r[OFS_W-1]}}, ofs_r};
    ofs_inc    = ofs_r + OFS_W'(1);
    at_end     = (cur_x_r == x1_r) && (cur_y_r == end_y);
    final_pass = $signed(ofs_r) >= $signed({1'b0, lim_r});
    e2         = {err_r, 1'b0};
    move_x     = $signed(e2) > $signed(-{3'b000, dy_r});
    move_y     = $signed(e2) < $signed({3'b000, dx_r});
    err_sum    = {err_r[ERR_W-1], err_r}
                 - (move_x ? {3'b000, dy_r} : E2_W'(0))
                 + (move_y ? {3'b000, dx_r} : E2_W'(0));

    active_nxt = active_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    err_nxt    = err_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    sxn_nxt    = sxn_r;
    syn_nxt    = syn_r;
    x0_nxt     = x0_r;
    y0_nxt     = y0_r;
    x1_nxt     = x1_r;
    y1_nxt     = y1_r;
    ofs_nxt    = ofs_r;
    lim_nxt    = lim_r;
    color_nxt  = color_r;

    if (load) begin
      // latch the line and open the first pass at offset -t/2
      x0_nxt     = x_start;
      y0_nxt     = y_start;
      x1_nxt     = x_end;
      y1_nxt     = y_end;
      color_nxt  = color;
      dx_nxt     = (x_end > x_start) ? x_end - x_start : x_start - x_end;
      dy_nxt     = (y_end > y_start) ? y_end - y_start : y_start - y_end;
      sxn_nxt    = !(x_start < x_end);
      syn_nxt    = !(y_start < y_end);
      lim_nxt    = thickness[THICK_W-1:1];
      ofs_nxt    = -{1'b0, thickness[THICK_W-1:1]};
      cur_x_nxt  = x_start;
      cur_y_nxt  = ROW_W'({2'b00, y_start}) - ROW_W'(thickness[THICK_W-1:1]);
      err_nxt    = ERR_W'({2'b00, dx_nxt}) - ERR_W'({2'b00, dy_nxt});
      active_nxt = 1'b1;
    end else if (advance) begin
      if (at_end) begin
        if (final_pass) begin
          active_nxt = 1'b0;
        end else begin
          // restart the walk one row lower
          ofs_nxt   = ofs_inc;
          cur_x_nxt = x0_r;
          cur_y_nxt = ROW_W'({2'b00, y0_r}) + {{(ROW_W-OFS_W){ofs_inc[OFS_W-1]}}, ofs_inc};
          err_nxt   = ERR_W'({2'b00, dx_r}) - ERR_W'({2'b00, dy_r});
        end
      end else begin
        err_nxt = err_sum[ERR_W-1:0];
        if (move_x) begin
          cur_x_nxt = sxn_r ? cur_x_r - COORD_W'(1) : cur_x_r + COORD_W'(1);
        end
        if (move_y) begin
          cur_y_nxt = syn_r ? cur_y_r - ROW_W'(1) : cur_y_r + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      err_r    <= '0;
      dx_r     <= '0;
      dy_r     <= '0;
      sxn_r    <= 1'b0;
      syn_r    <= 1'b0;
      x0_r     <= '0;
      y0_r     <= '0;
      x1_r     <= '0;
      y1_r     <= '0;
      ofs_r    <= '0;
      lim_r    <= '0;
      color_r  <= '0;
    end else begin
      active_r <= active_nxt;
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      err_r    <= err_nxt;
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      sxn_r    <= sxn_nxt;
      syn_r    <= syn_nxt;
      x0_r     <= x0_nxt;
      y0_r     <= y0_nxt;
      x1_r     <= x1_nxt;
      y1_r     <= y1_nxt;
      ofs_r    <= ofs_nxt;
      lim_r    <= lim_nxt;
      color_r  <= color_nxt;
    end
  end

  assign active     = active_r;
  assign pix.x      = cur_x_r;
  assign pix.y      = cur_y_r;
  assign pix.last   = at_end && final_pass;
  assign line_color = color_r;

  // the final pixel of a line must retire the line
  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !load && at_end && final_pass) |=> !active_r)
    else $error("line still active after its last pixel");

  // pass offset never runs past +t/2 while drawing
  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> ($signed(ofs_r) <= $signed({1'b0, lim_r})))
    else $error("pass offset beyond thickness limit");

endmodule

`default_nettype wire

@@ rtl/core/tlpg_pixel.sv @@
`default_nettype none

module tlpg_pixel
  import tlpg_pkg::*;
(
  input  wire tlpg_pix_t          pix,
  input  wire logic [COLOR_W-1:0] line_color,
  output logic                    on_image,
  output logic [ADDR_W-1:0]       byte_address,
  output logic [CHAN_W-1:0]       red,
  output logic [CHAN_W-1:0]       green,
  output logic [CHAN_W-1:0]       blue
);

  logic [LIN_W-1:0] lin;
  logic [LIN_W-1:0] lin_x3;

  always_comb begin
    on_image = !pix.y[ROW_W-1]
               && (LIN_W'(pix.y) < LIN_W'(IMAGE_HEIGHT))
               && (LIN_W'(pix.x) < LIN_W'(IMAGE_WIDTH));
    lin      = LIN_W'(pix.y) * LIN_W'(IMAGE_WIDTH) + LIN_W'(pix.x);
    lin_x3   = lin * LIN_W'(BYTES_PER_PIX);
    byte_address = on_image ? lin_x3[ADDR_W-1:0] : '0;
    red      = line_color[3*CHAN_W-1:2*CHAN_W];
    green    = line_color[2*CHAN_W-1:CHAN_W];
    blue     = line_color[CHAN_W-1:0];
  end

endmodule

`default_nettype wire

@@ dv/tb_thick_line_pixel_generator_unit.sv @@
module tb_thick_line_pixel_generator_unit;
  import tlpg_pkg::*;

  // One input transaction: the fields of a start or step command
  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    logic [COLOR_W-1:0] color;
    logic [THICK_W-1:0] thick;
  } line_cmd_t;

  // One output transaction: a pixel bound for the frame buffer
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [ROW_W-1:0]   y;
    logic               on;
    logic [ADDR_W-1:0]  addr;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic               last;
  } pixel_t;

  // How the pixel of a command is to be judged: by the line tracer below,
  // as "no pixel at all", or against a value written into the table
  typedef enum logic [1:0] {CHK_PREDICT, CHK_SILENT, CHK_TYPED} chk_e;

  typedef struct packed {
    chk_e   kind;
    pixel_t pix;
  } chk_t;

  typedef struct packed {
    line_cmd_t cmd;
    chk_t      chk;
  } dir_row_t;

  logic                    clk;
  logic                    rst_n        = 1'b0;
  logic                    in_valid     = 1'b0;
  logic                    in_ready;
  logic                    in_op        = OP_START;
  logic [COORD_W-1:0]      in_x_start   = '0;
  logic [COORD_W-1:0]      in_y_start   = '0;
  logic [COORD_W-1:0]      in_x_end     = '0;
  logic [COORD_W-1:0]      in_y_end     = '0;
  logic [COLOR_W-1:0]      in_color     = '0;
  logic [THICK_W-1:0]      in_thickness = '0;
  logic                    out_valid;
  logic                    out_ready    = 1'b0;
  logic [COORD_W-1:0]      out_pixel_x;
  logic signed [ROW_W-1:0] out_pixel_y;
  logic                    out_on_image;
  logic [ADDR_W-1:0]       out_byte_address;
  logic [CHAN_W-1:0]       out_red;
  logic [CHAN_W-1:0]       out_green;
  logic [CHAN_W-1:0]       out_blue;
  logic                    out_last_pixel;

  thick_line_pixel_generator_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_x_start       (in_x_start),
    .in_y_start       (in_y_start),
    .in_x_end         (in_x_end),
    .in_y_end         (in_y_end),
    .in_color         (in_color),
    .in_thickness     (in_thickness),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_on_image     (out_on_image),
    .out_byte_address (out_byte_address),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_last_pixel   (out_last_pixel)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Give up on a hung run long after the slowest legal one would be over
  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Traffic shaping shared by the sender and the receiver
  // ---------------------------------------------------------------------------
  int idle_pct  = 0;   // chance per cycle that the sender holds back
  int stall_pct = 0;   // chance per cycle that the receiver drops out_ready
  bit hold_req  = 1'b0;
  int hold_left = 0;

  // Receiver: stall at random, or for a long stretch on request so the
  // output register fills and the block has to push back on its input.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 240;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Line tracer: an independent copy of the walker state. It advances once per
  // accepted transaction and yields the pixel a step transaction should return.
  // ---------------------------------------------------------------------------
  bit                 ln_active = 1'b0;
  logic [COORD_W-1:0] ln_x      = '0;
  int                 ln_y, ln_err, ln_dx, ln_dy, ln_ofs, ln_lim;
  int                 ln_x0, ln_y0, ln_x1, ln_y1;
  bit                 ln_xneg, ln_yneg;
  logic [COLOR_W-1:0] ln_color  = '0;

  pixel_t pixel_q[$];   // pixels still owed by the block, oldest first
  chk_t   sent_q[$];    // judging mode of each offered command, in order
  int     items_sent     = 0;
  int     pixels_checked = 0;
  int     lines_started  = 0;
  int     lines_finished = 0;
  int     fail_count     = 0;

  // Rewind to the first endpoint of the current pass; the error term restarts
  task automatic open_pass();
    ln_x   = ln_x0[COORD_W-1:0];
    ln_y   = ln_y0 + ln_ofs;
    ln_err = ln_dx - ln_dy;
  endtask

  task automatic trace_pixel(input line_cmd_t c, output bit got, output pixel_t p);
    int px, py, ex, ey, e2;
    got = 1'b0;
    p   = '0;
    if (c.op == OP_START) begin
      // latch the line, drop whatever was in progress
      ln_x0    = int'(c.xs);
      ln_y0    = int'(c.ys);
      ln_x1    = int'(c.xe);
      ln_y1    = int'(c.ye);
      ln_color = c.color;
      ln_dx    = (ln_x1 > ln_x0) ? ln_x1 - ln_x0 : ln_x0 - ln_x1;
      ln_dy    = (ln_y1 > ln_y0) ? ln_y1 - ln_y0 : ln_y0 - ln_y1;
      ln_xneg  = !(ln_x0 < ln_x1);
      ln_yneg  = !(ln_y0 < ln_y1);
      ln_lim   = int'(c.thick >> 1);
      ln_ofs   = -ln_lim;
      open_pass();
      ln_active = 1'b1;
      lines_started++;
    end else if (ln_active) begin
      px = int'(ln_x);
      py = ln_y;
      ex = ln_x1;
      ey = ln_y1 + ln_ofs;
      got     = 1'b1;
      p.x     = ln_x;
      p.y     = py[ROW_W-1:0];
      p.on    = (py >= 0) && (py < IMAGE_HEIGHT) && (px < IMAGE_WIDTH);
      p.addr  = p.on ? ADDR_W'((py * IMAGE_WIDTH + px) * BYTES_PER_PIX) : '0;
      p.red   = ln_color[23:16];
      p.green = ln_color[15:8];
      p.blue  = ln_color[7:0];
      p.last  = 1'b0;
      if (px == ex && py == ey) begin
        // end of a pass: either the whole line is done or the next row starts
        if (ln_ofs >= ln_lim) begin
          p.last    = 1'b1;
          ln_active = 1'b0;
          lines_finished++;
        end else begin
          ln_ofs++;
          open_pass();
        end
      end else begin
        e2 = 2 * ln_err;
        if (e2 > -ln_dy) begin
          ln_err -= ln_dy;
          ln_x    = ln_xneg ? ln_x - 1'b1 : ln_x + 1'b1;
        end
        if (e2 < ln_dx) begin
          ln_err += ln_dx;
          ln_y   += ln_yneg ? -1 : 1;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Reporting
  // ---------------------------------------------------------------------------
  task automatic note_fail(input string msg);
    if (fail_count < 10)
      $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic string show_pixel(pixel_t p);
    return $sformatf("x=%0d y=%0d on=%0b addr=%0d rgb=%02h_%02h_%02h last=%0b",
                     p.x, $signed(p.y), p.on, p.addr, p.red, p.green, p.blue, p.last);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: both channels are sampled at the clock edge. Advance the tracer on
  // every accepted command, then hold each returned pixel against the oldest
  // one still owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    chk_t   want;
    bit     got;
    pixel_t calc;
    pixel_t owed;
    pixel_t seen;
    string  diffs;
    if (rst_n && in_valid && in_ready) begin
      want = sent_q.pop_front();
      trace_pixel('{in_op, in_x_start, in_y_start, in_x_end, in_y_end, in_color,
                    in_thickness}, got, calc);
      case (want.kind)
        CHK_TYPED:   pixel_q.push_back(want.pix);
        CHK_PREDICT: if (got) pixel_q.push_back(calc);
        default:     ;   // nothing may come back for this one
      endcase
    end
    if (rst_n && out_valid && out_ready) begin
      seen = '{out_pixel_x, out_pixel_y, out_on_image, out_byte_address, out_red,
               out_green, out_blue, out_last_pixel};
      pixels_checked++;
      if (pixel_q.size() == 0) begin
        note_fail($sformatf("unexpected pixel %s", show_pixel(seen)));
      end else begin
        owed  = pixel_q.pop_front();
        diffs = "";
        if (seen.x     !== owed.x)     diffs = {diffs, " pixel_x"};
        if (seen.y     !== owed.y)     diffs = {diffs, " pixel_y"};
        if (seen.on    !== owed.on)    diffs = {diffs, " on_image"};
        if (seen.addr  !== owed.addr)  diffs = {diffs, " byte_address"};
        if (seen.red   !== owed.red)   diffs = {diffs, " red"};
        if (seen.green !== owed.green) diffs = {diffs, " green"};
        if (seen.blue  !== owed.blue)  diffs = {diffs, " blue"};
        if (seen.last  !== owed.last)  diffs = {diffs, " last_pixel"};
        if (diffs != "")
          note_fail($sformatf("pixel %0d differs in%s: expected %s, got %s",
                              pixels_checked, diffs, show_pixel(owed), show_pixel(seen)));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Offer one transaction and hold it until accepted. Valid is only dropped
  // when the sender idles, so back-to-back transactions keep it high.
  task automatic push_item(input line_cmd_t c, input chk_t k);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    sent_q.push_back(k);
    in_valid     <= 1'b1;
    in_op        <= c.op;
    in_x_start   <= c.xs;
    in_y_start   <= c.ys;
    in_x_end     <= c.xe;
    in_y_end     <= c.ye;
    in_color     <= c.color;
    in_thickness <= c.thick;
    items_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Pause the sender until every owed pixel is back, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Endpoints lean on the image borders a good share of the time
  function automatic logic [COORD_W-1:0] edge_coord();
    int roll;
    roll = $urandom_range(99);
    if (roll < 20) return '0;
    if (roll < 40) return '1;
    return COORD_W'($urandom);
  endfunction

  function automatic logic [COORD_W-1:0] near(logic [COORD_W-1:0] base, int span);
    int v;
    v = int'(base) + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[COORD_W-1:0];
  endfunction

  function automatic line_cmd_t rand_cmd();
    line_cmd_t c;
    c.op    = 1'($urandom_range(1));
    c.xs    = edge_coord();
    c.ys    = edge_coord();
    c.xe    = edge_coord();
    c.ye    = edge_coord();
    c.color = COLOR_W'($urandom);
    c.thick = THICK_W'($urandom);
    return c;
  endfunction

  function automatic line_cmd_t start_cmd(int xs, int ys, int xe, int ye, int color,
                                          int th);
    return '{OP_START, xs[COORD_W-1:0], ys[COORD_W-1:0], xe[COORD_W-1:0],
             ye[COORD_W-1:0], color[COLOR_W-1:0], th[THICK_W-1:0]};
  endfunction

  // Step with junk in the fields the block ignores
  function automatic line_cmd_t step_cmd();
    line_cmd_t c;
    c    = rand_cmd();
    c.op = OP_STEP;
    return c;
  endfunction

  function automatic pixel_t pix(int x, int y, bit on, int addr, int color, bit last);
    return '{x[COORD_W-1:0], y[ROW_W-1:0], on, addr[ADDR_W-1:0], color[23:16],
             color[15:8], color[7:0], last};
  endfunction

  // One random line: mostly short lines walked to their end, some cut short by
  // a new start, some followed by steps that find the walker idle, and now and
  // then a long thin line across the image.
  task automatic random_line();
    line_cmd_t c;
    int        dx, dy, len, n, roll, span;
    c    = rand_cmd();
    c.op = OP_START;
    if ($urandom_range(99) < 3) begin
      c.thick = THICK_W'($urandom_range(1));
    end else begin
      span  = ($urandom_range(99) < 12) ? 1 : 6;
      c.xe  = near(c.xs, span);
      c.ye  = near(c.ys, span);
      if (span > 1)
        c.thick = THICK_W'($urandom_range(5));
    end
    dx   = (c.xe > c.xs) ? int'(c.xe - c.xs) : int'(c.xs - c.xe);
    dy   = (c.ye > c.ys) ? int'(c.ye - c.ys) : int'(c.ys - c.ye);
    len  = (int'(c.thick >> 1) * 2 + 1) * ((dx > dy ? dx : dy) + 1);
    roll = $urandom_range(99);
    if (roll < 10)
      n = $urandom_range(len - 1);
    else if (roll < 25)
      n = len + $urandom_range(1, 3);
    else
      n = len;
    push_item(c, '{CHK_PREDICT, '0});
    repeat (n) push_item(step_cmd(), '{CHK_PREDICT, '0});
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t tab[$];
    int       goal;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows. Typed pixels are the ones whose value is plain from the
    // geometry: single-point lines, first pixels, rows off the top edge.
    tab = '{
      // step with no line in progress: consumed, nothing back
      '{step_cmd(), '{CHK_SILENT, '0}},
      // one-pixel line, thickness 0, white
      '{start_cmd(0, 0, 0, 0, 24'hFFFFFF, 0), '{CHK_SILENT, '0}},
      '{step_cmd(), '{CHK_TYPED, pix(0, 0, 1'b1, 0, 24'hFFFFFF, 1'b1)}},
      '{step_cmd(), '{CHK_SILENT, '0}},
      // bottom-right corner, thickest line: first pass 15 rows up
      '{start_cmd(255, 255, 255, 255, 24'h000000, 31), '{CHK_SILENT, '0}},
      '{step_cmd(), '{CHK_TYPED, pix(255, 240, 1'b1, 185085, 24'h000000, 1'b0)}},
      '{step_cmd(), '{CHK_PREDICT, '0}},
      // start while a line is in progress; first pass lies above the image
      '{start_cmd(10, 0, 10, 0, 24'h123456, 2), '{CHK_SILENT, '0}},
      '{step_cmd(), '{CHK_TYPED, pix(10, -1, 1'b0, 0, 24'h123456, 1'b0)}},
      '{step_cmd(), '{CHK_TYPED, pix(10, 0, 1'b1, 30, 24'h123456, 1'b0)}},
      '{step_cmd(), '{CHK_TYPED, pix(10, 1, 1'b1, 798, 24'h123456, 1'b1)}},
      // full diagonal, thickness 1 is a single pass
      '{start_cmd(0, 0, 255, 255, 24'hA5C3E1, 1), '{CHK_SILENT, '0}},
      '{step_cmd(), '{CHK_TYPED, pix(0, 0, 1'b1, 0, 24'hA5C3E1, 1'b0)}},
      '{step_cmd(), '{CHK_PREDICT, '0}},
      // anti-diagonal walking left
      '{start_cmd(255, 0, 0, 255, 24'h5A3C1E, 0), '{CHK_SILENT, '0}},
      '{step_cmd(), '{CHK_TYPED, pix(255, 0, 1'b1, 765, 24'h5A3C1E, 1'b0)}},
      '{step_cmd(), '{CHK_PREDICT, '0}},
      // steep line walking up and left
      '{start_cmd(200, 255, 100, 0, 24'hC0FFEE, 3), '{CHK_SILENT, '0}},
      '{step_cmd(), '{CHK_TYPED, pix(200, 254, 1'b1, 195672, 24'hC0FFEE, 1'b0)}},
      '{step_cmd(), '{CHK_PREDICT, '0}},
      // short horizontal line walked to its end
      '{start_cmd(5, 3, 9, 3, 24'h00FF00, 1), '{CHK_SILENT, '0}},
      '{step_cmd(), '{CHK_PREDICT, '0}},
      '{step_cmd(), '{CHK_PREDICT, '0}},
      '{step_cmd(), '{CHK_PREDICT, '0}},
      '{step_cmd(), '{CHK_PREDICT, '0}},
      '{step_cmd(), '{CHK_PREDICT, '0}}
    };
    foreach (tab[i]) push_item(tab[i].cmd, tab[i].chk);
    drain();

    // Back-pressure: hold the receiver off while a 41-pixel line streams in
    hold_req = 1'b1;
    push_item(start_cmd(20, 100, 60, 110, $urandom, 1), '{CHK_SILENT, '0});
    repeat (41) push_item(step_cmd(), '{CHK_PREDICT, '0});
    drain();

    // Random phases: free flow, sender idling, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      goal = items_sent + 160;
      while (items_sent < goal) begin
        if ($urandom_range(99) < 5)
          push_item(rand_cmd(), '{CHK_PREDICT, '0});
        else
          random_line();
      end
      drain();
    end

    $display("summary: %0d transactions offered, %0d lines started, %0d walked to the end",
             items_sent, lines_started, lines_finished);
    $display("summary: %0d pixels checked over four traffic phases and one long hold-off",
             pixels_checked);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/tlpg_pkg.sv
rtl/core/tlpg_step.sv
rtl/core/tlpg_pixel.sv
rtl/core/thick_line_pixel_generator_unit.sv
dv/tb_thick_line_pixel_generator_unit.sv
